// ===== sv/rgbgs_pkg.sv =====
// rgbgs_pkg: shared types, codes and constants of the rgb565 gray nearest scaler
// holds the gray conversion function, the controller states and register indexes
// no dependencies
package rgbgs_pkg;

  localparam int REG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 16;
  localparam int GRAY_W    = 8;
  localparam int MUL_A_W   = REG_W + 1;
  localparam int DIV_W     = MUL_A_W + REG_W;
  localparam int CNT_W     = $clog2(DIV_W);

  localparam int DEF_MAX_SOURCE_WIDTH = 2048;
  localparam int DEF_MAX_ROWS         = 3072;

  typedef logic [REG_W-1:0]     word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SOURCE_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_SOURCE_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_TARGET_WIDTH  = 2'd2;
  localparam cfg_idx_t CFG_TARGET_HEIGHT = 2'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_READ,
    ST_EMIT
  } state_t;

  // c*255/31 = 8c + floor(7c/31), the second term as a reciprocal multiply
  localparam logic [15:0] RECIP_7_31 = 16'd1855;
  localparam int          RECIP_SH   = 13;

  function automatic logic [GRAY_W-1:0] gray565(logic [PIX_W-1:0] p);
    logic [4:0]  r5;
    logic [5:0]  g6;
    logic [4:0]  b5;
    logic [15:0] rr;
    logic [15:0] bb;
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [15:0] luma;
    r5 = p[15:11];
    g6 = p[10:5];
    b5 = p[4:0];
    rr = 16'(r5) * RECIP_7_31;
    bb = 16'(b5) * RECIP_7_31;
    r8 = {r5, 3'b000} + 8'(rr >> RECIP_SH);
    b8 = {b5, 3'b000} + 8'(bb >> RECIP_SH);
    // c*255/63 = 4c + floor(c/21)
    g8 = {g6, 2'b00} + 8'(g6 >= 6'd21) + 8'(g6 >= 6'd42) + 8'(g6 == 6'd63);
    luma = 16'(r8) * 16'd77 + 16'(g8) * 16'd150 + 16'(b8) * 16'd29;
    return luma[15:8];
  endfunction

endpackage

// ===== sv/rgbgs_pix_if.sv =====
// rgbgs_pix_if: input channel of the scaler, source pixels and drain ticks
// valid/ready handshake with op and pixel payload
// depends on rgbgs_pkg
interface rgbgs_pix_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [rgbgs_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output op, output pixel, input ready);
  modport sink   (input valid, input op, input pixel, output ready);
endinterface

// ===== sv/rgbgs_res_if.sv =====
// rgbgs_res_if: result channel of the scaler, one gray byte with row and image marks
// valid/ready handshake with gray_byte, row_end, image_end and rejected payload
// depends on rgbgs_pkg
interface rgbgs_res_if;
  logic                         valid;
  logic                         ready;
  logic [rgbgs_pkg::GRAY_W-1:0] gray_byte;
  logic                         row_end;
  logic                         image_end;
  logic                         rejected;

  modport source (output valid, output gray_byte, output row_end, output image_end,
                  output rejected, input ready);
  modport sink   (input valid, input gray_byte, input row_end, input image_end,
                  input rejected, output ready);
endinterface

// ===== sv/rgb565_gray_nearest_scaler.sv =====
// channel   | dir | payload                                   | transfer when
// ----------+-----+-------------------------------------------+---------------------
// in_ch     | in  | op, pixel                                 | valid && ready
// out_ch    | out | gray_byte, row_end, image_end, rejected   | valid && ready
// cfg       | in  | cfg_index, cfg_wdata                      | cfg_we
//
// the pixel that closes a source row adds two mul + 25-step divide passes through the
// shared bit-serial divider for the row mapping
// a sampling tick runs mul, divide, line store read and emit; a padding tick goes to emit only
// one item in flight at a time, the output register is the only buffer toward out_ch
// synchronous active-low reset, no clearing pass; a stalled out_ch holds in_ch off
//
// rgb565_gray_nearest_scaler: top level, depends on rgbgs_pkg, rgbgs_pix_if, rgbgs_res_if
module rgb565_gray_nearest_scaler #(
  parameter int MAX_SOURCE_WIDTH = rgbgs_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_ROWS         = rgbgs_pkg::DEF_MAX_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rgbgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbgs_pkg::REG_W-1:0]     cfg_wdata,
  rgbgs_pix_if.sink                       in_ch,
  rgbgs_res_if.source                     out_ch
);

  localparam int AW = (MAX_SOURCE_WIDTH > 1) ? $clog2(MAX_SOURCE_WIDTH) : 1;
  localparam int RW = rgbgs_pkg::REG_W;
  localparam int DW = rgbgs_pkg::DIV_W;
  localparam int MW = rgbgs_pkg::MUL_A_W;
  localparam int GW = rgbgs_pkg::GRAY_W;

  function automatic rgbgs_pkg::word_t eff(rgbgs_pkg::word_t v, int unsigned max_v);
    rgbgs_pkg::word_t res;
    res = v;
    if (v == '0) begin
      res = RW'(1);
    end else if (32'(v) > max_v) begin
      res = RW'(max_v);
    end
    return res;
  endfunction

  // configuration
  rgbgs_pkg::word_t src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  rgbgs_pkg::word_t sw_eff, sh_eff, tw_eff, th_eff;

  // block state
  rgbgs_pkg::state_t state_r, state_nxt;
  rgbgs_pkg::word_t  col_cnt_r, src_row_r, copies_r, out_pos_r, first_r;
  logic              final_row_r;
  logic              job_tick_r, phase_r;

  // shared multiply / divide
  logic [MW-1:0]               mul_a_r;
  logic [DW-1:0]               dvd_r;
  logic [RW-1:0]               rem_r;
  logic [rgbgs_pkg::CNT_W-1:0] cnt_r;
  rgbgs_pkg::word_t            mul_b, div_d;
  logic [RW:0]                 rem_sh, rem_diff;
  logic                        div_ge, div_last;
  logic [RW-1:0]               rem_nxt;
  logic [DW-1:0]               quo_nxt;

  // line store
  logic [GW-1:0] line_mem [MAX_SOURCE_WIDTH];
  logic [GW-1:0] rd_data_r;
  logic [31:0]   wr_idx;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          mem_we, wr_in_range;

  // pending result and output register
  logic          use_mem_r, pend_rend_r, pend_iend_r;
  logic          out_valid_r, out_rend_r, out_iend_r, out_rej_r;
  logic [GW-1:0] out_gray_r;
  logic          ld_out, ob_rend_nxt, ob_iend_nxt, ob_rej_nxt;
  logic [GW-1:0] ob_gray_nxt;

  // item decode
  logic             out_free, in_ready, in_fire, in_pix, pix_reject, pix_ok, tick_go;
  rgbgs_pkg::word_t col_inc, pos_inc, copies_dec;
  logic             row_done, row_last, pos_in_row, rend, iend;
  logic [RW:0]      row_bytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= RW'(1);
      src_h_r <= RW'(1);
      tgt_w_r <= RW'(1);
      tgt_h_r <= RW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgbgs_pkg::CFG_SOURCE_WIDTH:  src_w_r <= cfg_wdata;
        rgbgs_pkg::CFG_SOURCE_HEIGHT: src_h_r <= cfg_wdata;
        rgbgs_pkg::CFG_TARGET_WIDTH:  tgt_w_r <= cfg_wdata;
        rgbgs_pkg::CFG_TARGET_HEIGHT: tgt_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign sw_eff = eff(src_w_r, MAX_SOURCE_WIDTH);
  assign sh_eff = eff(src_h_r, MAX_ROWS);
  assign tw_eff = eff(tgt_w_r, MAX_SOURCE_WIDTH);
  assign th_eff = eff(tgt_h_r, MAX_ROWS);

  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_ready   = (state_r == rgbgs_pkg::ST_IDLE) && out_free;
  assign in_fire    = in_ch.valid && in_ready;
  assign in_pix     = (in_ch.op == rgbgs_pkg::OP_PIXEL);
  assign pix_reject = (copies_r != '0) || final_row_r;
  assign pix_ok     = in_fire && in_pix && !pix_reject;
  assign tick_go    = in_fire && !in_pix && (copies_r != '0);

  assign col_inc  = col_cnt_r + RW'(1);
  assign row_done = (col_inc >= sw_eff) || (col_inc == '0);
  assign row_last = ({1'b0, src_row_r} + (RW+1)'(1)) >= {1'b0, sh_eff};

  assign pos_inc    = out_pos_r + RW'(1);
  assign row_bytes  = ({1'b0, tw_eff} + (RW+1)'(3)) & ~(RW+1)'(3);
  assign rend       = ({1'b0, pos_inc} >= row_bytes) || (pos_inc == '0);
  assign copies_dec = copies_r - RW'(1);
  assign iend       = rend && (copies_dec == '0) && final_row_r;
  assign pos_in_row = out_pos_r < tw_eff;

  // bit-serial restoring divide
  assign mul_b    = job_tick_r ? sw_eff : th_eff;
  assign div_d    = job_tick_r ? tw_eff : sh_eff;
  assign rem_sh   = {rem_r, dvd_r[DW-1]};
  assign div_ge   = rem_sh >= {1'b0, div_d};
  assign rem_diff = rem_sh - {1'b0, div_d};
  assign rem_nxt  = div_ge ? rem_diff[RW-1:0] : rem_sh[RW-1:0];
  assign quo_nxt  = {dvd_r[DW-2:0], div_ge};
  assign div_last = (cnt_r == rgbgs_pkg::CNT_W'(DW - 1));

  always_comb begin
    state_nxt   = state_r;
    ld_out      = 1'b0;
    ob_gray_nxt = '0;
    ob_rend_nxt = 1'b0;
    ob_iend_nxt = 1'b0;
    ob_rej_nxt  = 1'b0;
    unique case (state_r)
      rgbgs_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_pix) begin
            if (pix_reject) begin
              ld_out     = 1'b1;
              ob_rej_nxt = 1'b1;
            end else if (row_done) begin
              state_nxt = rgbgs_pkg::ST_MUL;
            end
          end else if (copies_r != '0) begin
            state_nxt = pos_in_row ? rgbgs_pkg::ST_MUL : rgbgs_pkg::ST_EMIT;
          end
        end
      end
      rgbgs_pkg::ST_MUL: state_nxt = rgbgs_pkg::ST_DIV;
      rgbgs_pkg::ST_DIV: begin
        if (div_last) begin
          if (job_tick_r) begin
            state_nxt = rgbgs_pkg::ST_READ;
          end else if (!phase_r) begin
            state_nxt = rgbgs_pkg::ST_MUL;
          end else begin
            state_nxt = rgbgs_pkg::ST_IDLE;
          end
        end
      end
      rgbgs_pkg::ST_READ: state_nxt = rgbgs_pkg::ST_EMIT;
      rgbgs_pkg::ST_EMIT: begin
        if (out_free) begin
          ld_out      = 1'b1;
          ob_gray_nxt = use_mem_r ? rd_data_r : '0;
          ob_rend_nxt = pend_rend_r;
          ob_iend_nxt = pend_iend_r;
          state_nxt   = rgbgs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rgbgs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rgbgs_pkg::ST_IDLE;
      col_cnt_r   <= '0;
      src_row_r   <= '0;
      copies_r    <= '0;
      out_pos_r   <= '0;
      final_row_r <= 1'b0;
      job_tick_r  <= 1'b0;
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pix_ok) begin
        if (row_done) begin
          col_cnt_r  <= '0;
          src_row_r  <= src_row_r + RW'(1);
          job_tick_r <= 1'b0;
          phase_r    <= 1'b0;
          if (row_last) begin
            final_row_r <= 1'b1;
          end
        end else begin
          col_cnt_r <= col_inc;
        end
      end
      if (tick_go) begin
        job_tick_r <= 1'b1;
        if (rend) begin
          out_pos_r <= '0;
          copies_r  <= copies_dec;
        end else begin
          out_pos_r <= pos_inc;
        end
      end
      if (state_r == rgbgs_pkg::ST_MUL) begin
        cnt_r <= '0;
      end else if (state_r == rgbgs_pkg::ST_DIV) begin
        cnt_r <= cnt_r + rgbgs_pkg::CNT_W'(1);
      end
      if (state_r == rgbgs_pkg::ST_DIV && div_last && !job_tick_r) begin
        if (!phase_r) begin
          phase_r <= 1'b1;
        end else begin
          copies_r <= quo_nxt[RW-1:0] - first_r;
        end
      end
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ok && row_done) begin
      mul_a_r <= {1'b0, src_row_r};
    end
    if (tick_go) begin
      mul_a_r     <= {1'b0, out_pos_r};
      use_mem_r   <= pos_in_row;
      pend_rend_r <= rend;
      pend_iend_r <= iend;
    end
    if (state_r == rgbgs_pkg::ST_MUL) begin
      dvd_r <= DW'(mul_a_r) * DW'(mul_b);
      rem_r <= '0;
    end
    if (state_r == rgbgs_pkg::ST_DIV) begin
      dvd_r <= quo_nxt;
      rem_r <= rem_nxt;
      if (div_last && !job_tick_r && !phase_r) begin
        first_r <= quo_nxt[RW-1:0];
        mul_a_r <= mul_a_r + MW'(1);
      end
    end
    if (ld_out) begin
      out_gray_r <= ob_gray_nxt;
      out_rend_r <= ob_rend_nxt;
      out_iend_r <= ob_iend_nxt;
      out_rej_r  <= ob_rej_nxt;
    end
  end

  assign wr_idx      = 32'(col_cnt_r);
  assign wr_in_range = wr_idx < 32'(MAX_SOURCE_WIDTH);
  assign wr_addr     = wr_idx[AW-1:0];
  assign rd_addr     = dvd_r[AW-1:0];
  assign mem_we      = pix_ok && wr_in_range;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[wr_addr] <= rgbgs_pkg::gray565(in_ch.pixel);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rgbgs_pkg::ST_READ) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.gray_byte = out_gray_r;
  assign out_ch.row_end   = out_rend_r;
  assign out_ch.image_end = out_iend_r;
  assign out_ch.rejected  = out_rej_r;

endmodule

// ===== sv/rgbgs_chk.sv =====
// rgbgs_chk: port-level checks of the rgb565 gray nearest scaler
// bound to rgb565_gray_nearest_scaler; depends on rgbgs_pix_if and rgbgs_res_if
module rgbgs_chk (
  input logic         clk,
  input logic         rst_n,
  rgbgs_pix_if.sink   in_ch,
  rgbgs_res_if.source out_ch
);

  // a refused pixel carries no byte and no marks
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.rejected |->
      out_ch.gray_byte == '0 && !out_ch.row_end && !out_ch.image_end)
    else $error("rejected result with payload");

  a_image_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.image_end |-> out_ch.row_end && !out_ch.rejected)
    else $error("image end without row end");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");

  // a stalled result holds the input side off
  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

bind rgb565_gray_nearest_scaler rgbgs_chk u_rgbgs_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
